[rtl/cdg_pkg.sv]
// Package for the connection guard: id space sizing, opcode, state and status
// codes, and the command struct that drives the pending-id maps.
// No dependencies.
package cdg_pkg;

   localparam int ID_SPACE = 256;
   localparam int ID_W     = $clog2(ID_SPACE);
   localparam int CMP_W    = ID_W + 8;

   localparam logic [4:0] OPC_CONNECT   = 5'd0;
   localparam logic [4:0] OPC_CONNECT_R = 5'd1;
   localparam logic [4:0] OPC_RELEASE   = 5'd2;
   localparam logic [4:0] OPC_RELEASE_R = 5'd3;
   localparam logic [4:0] OPC_MAX       = 5'd17;

   localparam logic [1:0] ST_NONE       = 2'd0;
   localparam logic [1:0] ST_AWAITCON   = 2'd1;
   localparam logic [1:0] ST_CONNECTED  = 2'd2;
   localparam logic [1:0] ST_AWAITCLOSE = 2'd3;

   localparam logic [2:0] STS_OK          = 3'd0;
   localparam logic [2:0] STS_BAD_OPCODE  = 3'd1;
   localparam logic [2:0] STS_WRONG_STATE = 3'd2;
   localparam logic [2:0] STS_SENT_UNMAT  = 3'd3;
   localparam logic [2:0] STS_RECV_UNMAT  = 3'd4;
   localparam logic [2:0] STS_REMOTE_BUSY = 3'd5;
   localparam logic [2:0] STS_EXHAUSTED   = 3'd6;
   localparam logic [2:0] STS_OUT_RANGE   = 3'd7;

   typedef struct packed {
      logic            en;
      logic [ID_W-1:0] addr;
      logic            value;
   } map_cmd_type;

   function automatic logic [ID_W-1:0] wrap_next(input logic [ID_W-1:0] id);
      logic [ID_W-1:0] n;
      if (id == ID_W'(ID_SPACE - 1)) begin
         n = ID_W'(1);
      end else begin
         n = id + ID_W'(1);
      end
      return n;
   endfunction

endpackage

[rtl/cdap_connection_guard.sv]
// Top level of the connection guard: sequencer, link state, free-id search.
// Depends on cdg_pkg and cdg_pending_map (local and remote id maps).
//
//   channel | dir | tdata bits                              | tuser
//   req     | in  | opcode[4:0] msg_id[12:5]                | direction
//   rsp     | out | status[2:0] assigned_id[10:3] conn[12:11] | -
//
// A transaction passes from accept through FETCH (map read), EVAL (check) and
// FINISH (result) before the next accept. A sent request adds a free-id search
// over the local map that probes 1 to ID_SPACE-1 ids, one map bit read per cycle.
// Reset clears the link state and sets the id pointer to 1, then both maps are
// cleared one id per cycle; the input stays not ready until both maps are cleared.
// A result waits in the output register; the next transaction is taken
// meanwhile and holds in its final cycle until the register frees.
module cdap_connection_guard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // opcode[4:0], msg_id[12:5], zero fill
   input  logic        req_tuser,   // direction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[2:0], assigned_id[10:3],
                                    // conn_state[12:11], zero fill
);

   localparam int ID_W = cdg_pkg::ID_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FETCH  = 3'd1;
   localparam logic [2:0] S_EVAL   = 3'd2;
   localparam logic [2:0] S_SEARCH = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic            dir_ff, dir_in;
   logic [4:0]      opc_ff, opc_in;
   logic [7:0]      id_ff, id_in;
   logic [1:0]      link_ff, link_in;
   logic [1:0]      target_ff, target_in;
   logic [ID_W-1:0] next_id_ff, next_id_in;
   logic [ID_W-1:0] cand_ff, cand_in;
   logic [ID_W-1:0] tries_ff, tries_in;
   logic [2:0]      status_ff, status_in;
   logic [7:0]      assigned_ff, assigned_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     rsp_data_ff, rsp_data_in;

   logic                 is_reply, uses_in_id, bad_opc, ok, id_oor, slot_free;
   logic [1:0]           target;
   logic [ID_W-1:0]      id_idx;
   logic [ID_W-1:0]      local_addr;
   logic                 local_bit, remote_bit;
   logic                 local_ready, remote_ready, maps_ready;
   cdg_pkg::map_cmd_type local_cmd, remote_cmd;

   assign is_reply   = opc_ff[0];
   assign uses_in_id = dir_ff | is_reply;
   assign bad_opc    = opc_ff > cdg_pkg::OPC_MAX;
   assign id_oor     = cdg_pkg::CMP_W'(id_ff) >= cdg_pkg::CMP_W'(cdg_pkg::ID_SPACE);
   assign id_idx     = ID_W'(cdg_pkg::CMP_W'(id_ff));
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign maps_ready = local_ready && remote_ready;

   // local map read address; its bit is registered and shows up in the next cycle
   always_comb begin
      case (state_ff)
         S_EVAL:   local_addr = next_id_ff;
         S_SEARCH: local_addr = cdg_pkg::wrap_next(cand_ff);
         default:  local_addr = id_idx;
      endcase
   end

   always_comb begin
      case (opc_ff)
         cdg_pkg::OPC_CONNECT: begin
            ok = link_ff == cdg_pkg::ST_NONE;
            target = cdg_pkg::ST_AWAITCON;
         end
         cdg_pkg::OPC_CONNECT_R: begin
            ok = link_ff == cdg_pkg::ST_AWAITCON;
            target = cdg_pkg::ST_CONNECTED;
         end
         cdg_pkg::OPC_RELEASE: begin
            ok = link_ff == cdg_pkg::ST_CONNECTED;
            target = cdg_pkg::ST_AWAITCLOSE;
         end
         cdg_pkg::OPC_RELEASE_R: begin
            ok = link_ff == cdg_pkg::ST_AWAITCLOSE;
            target = cdg_pkg::ST_NONE;
         end
         default: begin
            ok = link_ff == cdg_pkg::ST_CONNECTED;
            target = link_ff;
         end
      endcase
   end

   cdg_pending_map u_local_map (
      .clock   (clock),
      .reset   (reset),
      .ready   (local_ready),
      .rd_addr (local_addr),
      .rd_bit  (local_bit),
      .cmd     (local_cmd)
   );

   cdg_pending_map u_remote_map (
      .clock   (clock),
      .reset   (reset),
      .ready   (remote_ready),
      .rd_addr (id_idx),
      .rd_bit  (remote_bit),
      .cmd     (remote_cmd)
   );

   always_comb begin
      state_in     = state_ff;
      dir_in       = dir_ff;
      opc_in       = opc_ff;
      id_in        = id_ff;
      link_in      = link_ff;
      target_in    = target_ff;
      next_id_in   = next_id_ff;
      cand_in      = cand_ff;
      tries_in     = tries_ff;
      status_in    = status_ff;
      assigned_in  = assigned_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      local_cmd    = '{en: 1'b0, addr: id_idx, value: 1'b0};
      remote_cmd   = '{en: 1'b0, addr: id_idx, value: 1'b0};

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && maps_ready) begin
               dir_in   = req_tuser;
               opc_in   = req_tdata[4:0];
               id_in    = req_tdata[12:5];
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            assigned_in = id_ff;
            status_in   = cdg_pkg::STS_OK;
            state_in    = S_FINISH;
            if (bad_opc) begin
               status_in = cdg_pkg::STS_BAD_OPCODE;
            end else if (!ok) begin
               status_in = cdg_pkg::STS_WRONG_STATE;
            end else if (uses_in_id && id_oor) begin
               status_in = cdg_pkg::STS_OUT_RANGE;
            end else if (!uses_in_id) begin
               target_in = target;
               cand_in   = next_id_ff;
               tries_in  = '0;
               state_in  = S_SEARCH;
            end else begin
               link_in = target;
               if (!dir_ff) begin
                  if (remote_bit) begin
                     remote_cmd.en = 1'b1;
                  end else begin
                     status_in = cdg_pkg::STS_SENT_UNMAT;
                  end
               end else if (is_reply) begin
                  if (local_bit) begin
                     local_cmd.en = 1'b1;
                  end else begin
                     status_in = cdg_pkg::STS_RECV_UNMAT;
                  end
               end else begin
                  if (remote_bit) begin
                     status_in = cdg_pkg::STS_REMOTE_BUSY;
                  end else begin
                     remote_cmd = '{en: 1'b1, addr: id_idx, value: 1'b1};
                  end
               end
            end
         end
         S_SEARCH: begin
            if (!local_bit) begin
               local_cmd   = '{en: 1'b1, addr: cand_ff, value: 1'b1};
               next_id_in  = cdg_pkg::wrap_next(cand_ff);
               assigned_in = 8'(cdg_pkg::CMP_W'(cand_ff));
               link_in     = target_ff;
               state_in    = S_FINISH;
            end else if (tries_ff == ID_W'(cdg_pkg::ID_SPACE - 2)) begin
               status_in = cdg_pkg::STS_EXHAUSTED;
               state_in  = S_FINISH;
            end else begin
               cand_in  = cdg_pkg::wrap_next(cand_ff);
               tries_in = tries_ff + ID_W'(1);
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, link_ff, assigned_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         link_ff      <= cdg_pkg::ST_NONE;
         next_id_ff   <= ID_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         link_ff      <= link_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff      <= dir_in;
      opc_ff      <= opc_in;
      id_ff       <= id_in;
      target_ff   <= target_in;
      cand_ff     <= cand_in;
      tries_ff    <= tries_in;
      status_ff   <= status_in;
      assigned_ff <= assigned_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE) && maps_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_next_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_id_ff != '0)
      else $error("local id pointer reached zero");

   a_search_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (tries_ff <= ID_W'(cdg_pkg::ID_SPACE - 2)))
      else $error("free-id search ran past the id space");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken again while an item is in progress");

   a_search_needs_connect: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (cand_ff != '0))
      else $error("search probed id zero");

endmodule

[rtl/cdg_pending_map.sv]
// One-bit-per-id pending map: registered read port, one write command, and a
// clearing pass after reset. Depends on cdg_pkg for the id width and command struct.
module cdg_pending_map (
   input  logic                      clock,
   input  logic                      reset,
   output logic                      ready,
   input  logic [cdg_pkg::ID_W-1:0]  rd_addr,
   output logic                      rd_bit,
   input  cdg_pkg::map_cmd_type      cmd
);

   localparam int ID_W = cdg_pkg::ID_W;

   logic            pending_mem [cdg_pkg::ID_SPACE];
   logic            rd_bit_ff;
   logic            clearing_ff, clearing_in;
   logic [ID_W-1:0] clr_addr_ff, clr_addr_in;
   logic            wr_en;
   logic [ID_W-1:0] wr_addr;
   logic            wr_bit;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + ID_W'(1);
         if (clr_addr_ff == ID_W'(cdg_pkg::ID_SPACE - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   assign wr_en   = clearing_ff || cmd.en;
   assign wr_addr = clearing_ff ? clr_addr_ff : cmd.addr;
   assign wr_bit  = !clearing_ff && cmd.value;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pending_mem[wr_addr] <= wr_bit;
      end
      rd_bit_ff <= pending_mem[rd_addr];
   end

   assign ready  = !clearing_ff;
   assign rd_bit = rd_bit_ff;

endmodule
